// ----- sv/dedup_stack_with_bottom_removal_core_defines.svh -----
`ifndef DEDUP_STACK_WITH_BOTTOM_REMOVAL_CORE_DEFINES_SVH
`define DEDUP_STACK_WITH_BOTTOM_REMOVAL_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define DSBR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dsbr check failed");

// next-cycle implication, sampled on clk, off during reset
`define DSBR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsbr check failed");

`endif

// ----- sv/dsbr_pkg.sv -----
`timescale 1ns / 1ps

package dsbr_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  localparam logic FN_PUSH   = 1'b0;
  localparam logic FN_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    ST_PUSHED    = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

endpackage

// ----- sv/dedup_stack_with_bottom_removal_core.sv -----
`timescale 1ns / 1ps
// Flow: a push scans the held entries from the oldest, one read per cycle, each compared
// against the pushed value as its registered read data returns; a drain step follows
// the last read, then the result loads into the output register. A hit ends the scan
// early; an empty store skips the reads. A removal goes straight to the output load.
// One item at a time: the next item is taken once the result loads; a stalled result holds.
// Reset (rst_n low, synchronous): store empty, pointers zero, no result pending.
module dedup_stack_with_bottom_removal_core #(
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_func,
  input  logic signed [dsbr_pkg::VALUE_W-1:0]  in_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [2:0]                    out_status,
  output logic        [dsbr_pkg::COUNT_W-1:0]  out_entry_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int OW = dsbr_pkg::COUNT_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  logic signed [dsbr_pkg::VALUE_W-1:0] entry_store_r [DEPTH];

  dsbr_pkg::state_t  state_r, state_nxt;
  dsbr_pkg::status_t res_r, res_nxt;
  logic signed [dsbr_pkg::VALUE_W-1:0] val_r, val_nxt;
  logic signed [dsbr_pkg::VALUE_W-1:0] rd_data_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic [AW-1:0] new_ptr_r, new_ptr_nxt;
  logic [AW-1:0] old_ptr_r, old_ptr_nxt;
  logic [AW-1:0] scan_ptr_r, scan_ptr_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_status_r, out_status_nxt;
  logic [OW-1:0] out_count_r, out_count_nxt;
  logic          wr_en;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    ring_next = (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  assign in_stall        = (state_r != dsbr_pkg::S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

  always_comb begin
    state_nxt      = state_r;
    res_nxt        = res_r;
    val_nxt        = val_r;
    cnt_nxt        = cnt_r;
    iss_nxt        = iss_r;
    new_ptr_nxt    = new_ptr_r;
    old_ptr_nxt    = old_ptr_r;
    scan_ptr_nxt   = scan_ptr_r;
    rd_vld_nxt     = rd_vld_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    wr_en          = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      dsbr_pkg::S_IDLE: begin
        if (in_valid) begin
          val_nxt      = in_value;
          scan_ptr_nxt = old_ptr_r;
          iss_nxt      = '0;
          rd_vld_nxt   = 1'b0;
          if (in_func == dsbr_pkg::FN_PUSH) begin
            state_nxt = dsbr_pkg::S_SCAN;
          end else begin
            if (cnt_r == '0) begin
              res_nxt = dsbr_pkg::ST_EMPTY;
            end else begin
              old_ptr_nxt = ring_next(old_ptr_r);
              cnt_nxt     = cnt_r - 1'b1;
              res_nxt     = dsbr_pkg::ST_REMOVED;
            end
            state_nxt = dsbr_pkg::S_DONE;
          end
        end
      end
      dsbr_pkg::S_SCAN: begin
        rd_vld_nxt = (iss_r != cnt_r);
        if (iss_r != cnt_r) begin
          iss_nxt      = iss_r + 1'b1;
          scan_ptr_nxt = ring_next(scan_ptr_r);
        end
        if (rd_vld_r && (rd_data_r == val_r)) begin
          res_nxt   = dsbr_pkg::ST_DUPLICATE;
          state_nxt = dsbr_pkg::S_DONE;
        end else if (!rd_vld_r && (iss_r == cnt_r)) begin
          if (cnt_r == FULL_CNT) begin
            res_nxt = dsbr_pkg::ST_FULL;
          end else begin
            wr_en       = 1'b1;
            new_ptr_nxt = ring_next(new_ptr_r);
            cnt_nxt     = cnt_r + 1'b1;
            res_nxt     = dsbr_pkg::ST_PUSHED;
          end
          state_nxt = dsbr_pkg::S_DONE;
        end
      end
      dsbr_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_r;
          out_count_nxt  = OW'(cnt_r);
          state_nxt      = dsbr_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dsbr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dsbr_pkg::S_IDLE;
      cnt_r       <= '0;
      new_ptr_r   <= '0;
      old_ptr_r   <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      new_ptr_r   <= new_ptr_nxt;
      old_ptr_r   <= old_ptr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r        <= res_nxt;
    val_r        <= val_nxt;
    iss_r        <= iss_nxt;
    scan_ptr_r   <= scan_ptr_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_store_r[new_ptr_r] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= entry_store_r[scan_ptr_r];
  end

endmodule

// ----- sv/dsbr_checker.sv -----
`timescale 1ns / 1ps
`include "dedup_stack_with_bottom_removal_core_defines.svh"

module dsbr_checker #(
  parameter int DEPTH = 16
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [2:0]                     out_status,
  input logic [dsbr_pkg::COUNT_W-1:0]   out_entry_count
);

  localparam int OW = dsbr_pkg::COUNT_W;
  localparam logic [OW-1:0] FULL_SEEN = OW'(DEPTH);

  `DSBR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_entry_count))
  `DSBR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `DSBR_ASSERT_NOW(a_empty_count, out_valid && (out_status == dsbr_pkg::ST_EMPTY), out_entry_count == '0)
  `DSBR_ASSERT_NOW(a_full_count, out_valid && (out_status == dsbr_pkg::ST_FULL), out_entry_count == FULL_SEEN)

endmodule

bind dedup_stack_with_bottom_removal_core dsbr_checker #(.DEPTH(DEPTH)) u_dsbr_checker (.*);
